### hdl/slis_pkg.sv
// Shared types, codes and constants for the sorted insertion list.
`default_nettype none
package slis_pkg;

  // Default number of entries in the store.
  localparam int DEPTH_DEF = 16;

  // Field widths.
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;
  localparam int POS_W  = 5;
  localparam int CNT_W  = 5;
  localparam int OUT_W  = 16;

  // Operation codes carried in tuser.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

  typedef logic signed [VAL_W-1:0] val_t;

  // Flags that one cell hands to its right-hand neighbor.
  typedef struct packed {
    logic ge;    // occupied and holding a value >= the broadcast value
    logic take;  // cell lies between the insert slot and the end of the list
  } cell_flags_t;

endpackage
`default_nettype wire

### hdl/slis_cell.sv
// One storage cell of the sorted insertion list chain.
`default_nettype none
module slis_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  wire logic                 clk,
  input  wire slis_pkg::val_t       value,
  input  wire logic                 ins_en,
  input  wire logic [CW-1:0]        count,
  input  wire slis_pkg::val_t       left_val,
  input  wire slis_pkg::cell_flags_t left_flags,
  output slis_pkg::val_t            val,
  output slis_pkg::cell_flags_t     flags,
  output logic                      hit
);
  import slis_pkg::*;

  val_t val_r;
  val_t val_nxt;
  logic occ;
  logic at_end;

  // Occupancy follows from the element count and this cell's place.
  assign occ    = count > CW'(IDX);
  assign at_end = count == CW'(IDX);

  assign flags.ge   = occ && !(val_r < value);
  assign flags.take = flags.ge || at_end;

  // The first cell that holds a value >= the key is the only candidate match.
  assign hit = flags.ge && !left_flags.ge && (val_r == value);

  // On insert, the slot cell loads the key and the cells after it shift right.
  always_comb begin
    val_nxt = val_r;
    if (ins_en && flags.take) begin
      val_nxt = left_flags.take ? left_val : value;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule
`default_nettype wire

### hdl/sorted_list_insert_search.sv
// Top level of the sorted insertion list: cell chain, count and result register.
`default_nettype none
// Keeps up to DEPTH signed 32-bit values in ascending order in a row of cells.
// An insert (tuser 0) places the value ahead of equal ones; a search (tuser 1)
// returns the 1-based position of the first equal entry. For each item the
// value is broadcast to every cell, each cell compares it with its own entry,
// and on an insert the cells from the slot on shift right in the same edge.
// The result lands in an output register in the cycle after the input
// transaction, and a new item is taken every cycle while that register is free
// or being read. The cycle time is set by the 32-bit compare in each cell and
// the OR of the match position over all cells. No clearing pass after reset.
module sorted_list_insert_search #(
  parameter int DEPTH = slis_pkg::DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [slis_pkg::VAL_W-1:0] in_tdata,  // [31:0] value
  input  wire logic [0:0]                in_tuser,  // [0] func
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [slis_pkg::OUT_W-1:0]     out_tdata  // [2:0] status, [7:3] position,
                                                    // [12:8] count, [15:13] zero
);
  import slis_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r;
  logic [OUT_W-1:0]    out_data_nxt;

  logic                accept;
  logic                is_search;
  logic                full;
  logic                empty;
  logic                ins_en;
  val_t                key;
  val_t                vals  [DEPTH];
  cell_flags_t         flags [DEPTH];
  logic [DEPTH-1:0]    hits;
  logic [STAT_W-1:0]   status;
  logic [POS_W-1:0]    position;
  logic [31:0]         count_wide;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign is_search = in_tuser[0] == FUNC_SEARCH;
  assign key       = val_t'(in_tdata);
  assign full      = count_r == CW'(DEPTH);
  assign empty     = count_r == '0;
  assign ins_en    = accept && !is_search && !full;

  // Chain of cells, each fed by its left-hand neighbor.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    val_t        lval;
    cell_flags_t lflags;
    if (g == 0) begin : g_head
      assign lval   = key;
      assign lflags = '0;
    end else begin : g_link
      assign lval   = vals[g-1];
      assign lflags = flags[g-1];
    end
    slis_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .value      (key),
      .ins_en     (ins_en),
      .count      (count_r),
      .left_val   (lval),
      .left_flags (lflags),
      .val        (vals[g]),
      .flags      (flags[g]),
      .hit        (hits[g])
    );
  end

  // At most one cell reports a hit, so its position is a plain OR.
  always_comb begin
    position = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hits[i]) begin
        position = position | POS_W'(i + 1);
      end
    end
  end

  // Result status and next count.
  always_comb begin
    count_nxt = ins_en ? count_r + CW'(1) : count_r;
    priority if (!is_search && full) begin
      status = ST_FULL;
    end else if (!is_search) begin
      status = ST_INSERTED;
    end else if (empty) begin
      status = ST_EMPTY;
    end else if (|hits) begin
      status = ST_FOUND;
    end else begin
      status = ST_NOT_FOUND;
    end
  end

  assign count_wide = 32'(count_nxt);

  // Output register: loads on an input transaction, clears when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'b000, count_wide[CNT_W-1:0],
                       (status == ST_FOUND) ? position : POS_W'(0), status};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

### hdl/slis_chk.sv
// Port-level checker for the sorted insertion list, bound to the top level.
`default_nettype none
module slis_chk #(
  parameter int DEPTH = slis_pkg::DEPTH_DEF
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_tready,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic [slis_pkg::OUT_W-1:0] out_tdata
);
  import slis_pkg::*;

  logic [STAT_W-1:0] st;
  logic [POS_W-1:0]  pos;
  logic [CNT_W-1:0]  cnt;

  assign st  = out_tdata[2:0];
  assign pos = out_tdata[7:3];
  assign cnt = out_tdata[12:8];

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A held result must not let a new input transaction through.
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result is stalled");

  // Only a found search carries a nonzero position.
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st != ST_FOUND |-> pos == '0)
    else $error("position set on a result that is not a match");

  // Empty and full reports agree with the count.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_EMPTY |-> cnt == '0)
    else $error("empty status with nonzero count");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_FULL |-> cnt == CNT_W'(DEPTH))
    else $error("full status with count below depth");

endmodule

bind sorted_list_insert_search slis_chk #(.DEPTH(DEPTH)) u_slis_chk (.*);
`default_nettype wire

### sim/sorted_list_insert_search_tb.sv
// Self-checking testbench for the sorted insertion list with a shadow store and reply checker.
`default_nettype none
module sorted_list_insert_search_tb;
  import slis_pkg::*;

  localparam int LIST_DEPTH  = DEPTH_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1200;
  localparam val_t VAL_MIN = val_t'(32'h8000_0000);
  localparam val_t VAL_MAX = val_t'(32'h7fff_ffff);

  // One expected reply, split into the fields of out_tdata.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [CNT_W-1:0]  count;
  } reply_t;

  // Shadow copy of the sorted store; it predicts the reply to every accepted
  // request and checks the replies in order.
  class sorted_store_shadow;
    val_t        entries[LIST_DEPTH];
    int unsigned n_stored = 0;
    reply_t      due_replies[$];
    int unsigned n_errors = 0;
    int unsigned n_checked = 0;
    int unsigned tally[8];

    // Note a request taken by the block and queue the reply it must produce.
    function void log_request(logic op, val_t v);
      reply_t want;
      int unsigned slot;
      want.position = '0;
      if (op == FUNC_INSERT) begin
        if (n_stored >= LIST_DEPTH) begin
          want.status = ST_FULL;
        end else begin
          // The new value goes ahead of the first entry that is equal or greater.
          slot = 0;
          while (slot < n_stored && entries[slot] < v) slot++;
          for (int i = n_stored; i > slot; i--) entries[i] = entries[i-1];
          entries[slot] = v;
          n_stored++;
          want.status = ST_INSERTED;
        end
      end else if (n_stored == 0) begin
        want.status = ST_EMPTY;
      end else begin
        want.status = ST_NOT_FOUND;
        for (int i = 0; i < n_stored; i++) begin
          if (entries[i] == v) begin
            want.status   = ST_FOUND;
            want.position = POS_W'(i + 1);
            break;
          end
        end
      end
      want.count = CNT_W'(n_stored);
      tally[want.status]++;
      due_replies.push_back(want);
    endfunction

    function void flag(string what, int unsigned want, int unsigned got);
      n_errors++;
      if (n_errors <= 10)
        $display("MISMATCH reply %0d %s: expected %0d, got %0d", n_checked, what, want, got);
    endfunction

    // Compare one reply taken from the block with the oldest expectation.
    function void check_reply(logic [OUT_W-1:0] d);
      reply_t want;
      if (due_replies.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("MISMATCH unexpected reply %h", d);
        return;
      end
      want = due_replies.pop_front();
      if (d[2:0] !== want.status)   flag("status", want.status, d[2:0]);
      if (d[7:3] !== want.position) flag("position", want.position, d[7:3]);
      if (d[12:8] !== want.count)   flag("count", want.count, d[12:8]);
      if (d[15:13] !== 3'b000)      flag("padding", 0, d[15:13]);
      n_checked++;
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [VAL_W-1:0] in_tdata = '0;   // [31:0] value
  logic [0:0]       in_tuser = '0;   // [0] func
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;       // [2:0] status, [7:3] position, [12:8] count

  sorted_store_shadow shadow = new();
  int unsigned        quiet_cycles = 0;
  logic [7:0]         stall_phase = '0;

  sorted_list_insert_search #(.DEPTH(LIST_DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  // Monitor: requests are logged before replies that land on the same edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) shadow.log_request(in_tuser[0], val_t'(in_tdata));
    if (rst_n && out_tvalid && out_tready) shadow.check_reply(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver back-pressure: rotates through always ready, half, mostly stalled
  // and a fixed one-in-eight stall pattern.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 8'd1;
    case (stall_phase[7:6])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 1) == 1);
      2'd2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (stall_phase[2:0] != 3'd0);
    endcase
  end

  // Watchdog: the run ends when no transaction has happened for too long.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout after %0d idle cycles", QUIET_LIMIT);
    $display("sorted_list_insert_search_tb NOT OK");
    $finish;
  end

  // Present one request and hold it until the block takes it.
  task automatic send_item(input logic op, input val_t v);
    in_tvalid   <= 1'b1;
    in_tuser[0] <= op;
    in_tdata    <= v;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic hold_off(input int unsigned n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Values drawn from extremes, a narrow band, the full range and stored entries.
  function automatic val_t pick_value();
    val_t v;
    case ($urandom_range(0, 6))
      0: v = val_t'($urandom);
      1: v = val_t'($urandom_range(0, 8)) - val_t'(4);
      2: begin
        case ($urandom_range(0, 5))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = VAL_MIN + val_t'(1);
          3: v = VAL_MAX - val_t'(1);
          4: v = '0;
          default: v = -val_t'(1);
        endcase
      end
      3: begin
        v = (shadow.n_stored > 0) ? shadow.entries[$urandom_range(0, shadow.n_stored - 1)]
                                  : val_t'($urandom);
        v = v + val_t'($urandom_range(0, 2)) - val_t'(1);
      end
      default: v = (shadow.n_stored > 0)
                   ? shadow.entries[$urandom_range(0, shadow.n_stored - 1)]
                   : val_t'($urandom);
    endcase
    return v;
  endfunction

  initial begin
    int unsigned burst_left;
    logic        op;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty search, extremes, equal values and absent values.
    send_item(FUNC_SEARCH, val_t'(5));
    send_item(FUNC_INSERT, val_t'(0));
    send_item(FUNC_SEARCH, val_t'(0));
    send_item(FUNC_INSERT, VAL_MAX);
    send_item(FUNC_INSERT, VAL_MIN);
    send_item(FUNC_INSERT, -val_t'(1));
    send_item(FUNC_INSERT, val_t'(0));
    send_item(FUNC_SEARCH, val_t'(0));
    send_item(FUNC_SEARCH, VAL_MAX);
    send_item(FUNC_SEARCH, VAL_MIN);
    send_item(FUNC_SEARCH, val_t'(1));
    send_item(FUNC_INSERT, VAL_MAX);
    send_item(FUNC_SEARCH, VAL_MAX - val_t'(1));

    // Let every pending reply drain before the random traffic starts, after first
    // waiting so that the monitor has logged the last request.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (shadow.due_replies.size() != 0) @(posedge clk);

    // Random traffic in bursts; inserts and searches are equally likely until the store
    // is full, after which searches dominate and the inserts that follow are dropped.
    burst_left = $urandom_range(1, 16);
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (shadow.n_stored < LIST_DEPTH) op = ($urandom_range(0, 1) == 0) ? FUNC_INSERT
                                                                      : FUNC_SEARCH;
      else op = ($urandom_range(0, 4) == 0) ? FUNC_INSERT : FUNC_SEARCH;
      send_item(op, pick_value());
      burst_left--;
      if (burst_left == 0) begin
        hold_off($urandom_range(1, 6));
        burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
      end
    end
    in_tvalid <= 1'b0;

    // Drain, then keep watching to catch any stray reply.
    @(posedge clk);
    while (shadow.due_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (shadow.due_replies.size() != 0) shadow.n_errors++;

    $display("replies checked %0d: inserted %0d, dropped when full %0d",
             shadow.n_checked, shadow.tally[ST_INSERTED], shadow.tally[ST_FULL]);
    $display("searches: found %0d, not found %0d, on empty store %0d, mismatches %0d",
             shadow.tally[ST_FOUND], shadow.tally[ST_NOT_FOUND], shadow.tally[ST_EMPTY],
             shadow.n_errors);
    if (shadow.n_errors == 0) begin
      $display("sorted_list_insert_search_tb OK");
    end else begin
      $display("sorted_list_insert_search_tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
hdl/slis_pkg.sv
hdl/slis_cell.sv
hdl/sorted_list_insert_search.sv
hdl/slis_chk.sv
sim/sorted_list_insert_search_tb.sv
